### rtl/bptc_pkg.sv
package bptc_pkg;

	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 15;
	localparam int PRES_W = 17;
	localparam int IDX_W  = 3;

	// internal widths
	localparam int DT_W   = RAW_W + 1;         // dT, signed
	localparam int PROD_W = DT_W + CAL_W + 1;  // dT times a calibration word
	localparam int SQ_W   = 2 * DT_W;          // dT squared
	localparam int Q_W    = 19;                // first-order temperature minus 2000
	localparam int E_W    = Q_W + 1;           // first-order temperature plus 1500
	localparam int T2_W   = 18;
	localparam int TMP_W  = 22;                // corrected temperature before clamp
	localparam int OS_W   = 40;                // offset and sensitivity
	localparam int HALF_W = OS_W / 2;          // split of sensitivity for the product
	localparam int P64_W  = 64;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SENS_BASE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_BASE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
	localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
	localparam logic [IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;

	localparam int TEMP_BASE  = 2000;
	localparam int TEMP_VLOW  = -1500;
	localparam int TEMP_LOW   = -4000;
	localparam int TEMP_HIGH  = 8500;
	localparam int PRES_LOW   = 1000;
	localparam int PRES_HIGH  = 120000;

	localparam int LATENCY = 9;

endpackage

### rtl/baro_pressure_temp_compensation_unit.sv
// Channel   Ports                                         Handshake
// request   start, busy, raw_pressure, raw_temperature    taken when start & !busy
// result    done, temperature, pressure, out_of_range     one-cycle strobe on done
// config    cfg_wr_en, cfg_index, cfg_wdata               written when cfg_wr_en
//
// Nine-stage pipeline: done is registered alongside the stage-nine outputs,
// and a new request is taken in every cycle (busy stays low).
// The depth is set by the multiplier stages: dT products, the squares of the
// second-order terms and the split pressure product each own a stage.
// arst_n clears the valid bits, done and the calibration registers.
// The receiver cannot stall, so no stage ever holds.
module baro_pressure_temp_compensation_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_temperature,
	output logic                                done,
	output logic signed [bptc_pkg::TEMP_W-1:0]  temperature,
	output logic [bptc_pkg::PRES_W-1:0]         pressure,
	output logic                                out_of_range,
	input  logic                                cfg_wr_en,
	input  logic [bptc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bptc_pkg::CAL_W-1:0]          cfg_wdata
);
	import bptc_pkg::*;

	logic [CAL_W-1:0] sens_base_q, offset_base_q, sens_tempco_q;
	logic [CAL_W-1:0] offset_tempco_q, ref_temp_q, temp_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_base_q     <= '0;
			offset_base_q   <= '0;
			sens_tempco_q   <= '0;
			offset_tempco_q <= '0;
			ref_temp_q      <= '0;
			temp_slope_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SENS_BASE:     sens_base_q     <= cfg_wdata;
				REG_OFFSET_BASE:   offset_base_q   <= cfg_wdata;
				REG_SENS_TEMPCO:   sens_tempco_q   <= cfg_wdata;
				REG_OFFSET_TEMPCO: offset_tempco_q <= cfg_wdata;
				REG_REF_TEMP:      ref_temp_q      <= cfg_wdata;
				REG_TEMP_SLOPE:    temp_slope_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			done_q <= v_s8;
		end
	end

	// stage 1: dT
	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0]       d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;

	always_ff @(posedge clk) begin
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_q, 8'h00});
		d1_s1 <= raw_pressure;
	end

	// stage 2: dT products
	logic signed [PROD_W-1:0] tc_s2, oc_s2, sc_s2;
	logic signed [SQ_W-1:0]   sq_s2;

	always_ff @(posedge clk) begin
		tc_s2 <= dt_s1 * $signed({1'b0, temp_slope_q});
		oc_s2 <= dt_s1 * $signed({1'b0, offset_tempco_q});
		sc_s2 <= dt_s1 * $signed({1'b0, sens_tempco_q});
		sq_s2 <= dt_s1 * dt_s1;
		d1_s2 <= d1_s1;
	end

	// stage 3: first-order terms
	logic signed [Q_W-1:0]  q_c, q_s3;
	logic signed [E_W-1:0]  e_s3;
	logic signed [OS_W-1:0] off1_s3, sens1_s3, off1_s4, sens1_s4, off1_s5, sens1_s5;
	logic [T2_W-1:0]        t2_s3;
	logic                   low_s3, vlow_s3, low_s4, vlow_s4, low_s5;

	assign q_c = tc_s2[PROD_W-1:23];

	always_ff @(posedge clk) begin
		q_s3     <= q_c;
		e_s3     <= E_W'(q_c) + E_W'(TEMP_BASE - TEMP_VLOW);
		low_s3   <= q_c[Q_W-1];
		vlow_s3  <= q_c < (TEMP_VLOW - TEMP_BASE);
		t2_s3    <= sq_s2[T2_W+30:31];
		off1_s3  <= $signed({8'b0, offset_base_q, 16'h0000})
			+ $signed({{5{oc_s2[PROD_W-1]}}, oc_s2[PROD_W-1:7]});
		sens1_s3 <= $signed({9'b0, sens_base_q, 15'h0000})
			+ $signed({{6{sc_s2[PROD_W-1]}}, sc_s2[PROD_W-1:8]});
		d1_s3    <= d1_s2;
	end

	// stage 4: squares of the second-order terms, corrected temperature
	logic signed [2*Q_W-1:0] f_s4;
	logic signed [2*E_W-1:0] g_s4;
	logic signed [TMP_W-1:0] temp_s4;

	always_ff @(posedge clk) begin
		f_s4     <= q_s3 * q_s3;
		g_s4     <= e_s3 * e_s3;
		temp_s4  <= TMP_W'(TEMP_BASE) + TMP_W'(q_s3)
			- (low_s3 ? $signed({{(TMP_W-T2_W){1'b0}}, t2_s3}) : TMP_W'(0));
		off1_s4  <= off1_s3;
		sens1_s4 <= sens1_s3;
		low_s4   <= low_s3;
		vlow_s4  <= vlow_s3;
		d1_s4    <= d1_s3;
	end

	// stage 5: OFF2 and SENS2
	logic [OS_W-1:0] f40, g40, five_f, seven_g, eleven_g;
	logic [OS_W-1:0] off2_s5, sens2_s5;
	logic signed [TMP_W-1:0] temp_s5;

	always_comb begin
		f40      = {2'b00, f_s4[2*Q_W-1:0]};
		g40      = g_s4[OS_W-1:0];
		five_f   = (f40 << 2) + f40;
		seven_g  = (g40 << 3) - g40;
		eleven_g = (g40 << 3) + (g40 << 1) + g40;
	end

	always_ff @(posedge clk) begin
		off2_s5  <= (five_f >> 1) + (vlow_s4 ? seven_g : '0);
		sens2_s5 <= (five_f >> 2) + (vlow_s4 ? (eleven_g >> 1) : '0);
		off1_s5  <= off1_s4;
		sens1_s5 <= sens1_s4;
		low_s5   <= low_s4;
		temp_s5  <= temp_s4;
		d1_s5    <= d1_s4;
	end

	// stage 6: final OFF and SENS, clamp temperature
	logic signed [OS_W-1:0]   off_s6, sens_s6, off_s7, off_s8;
	logic signed [TEMP_W-1:0] tsat_s6, tsat_s7, tsat_s8;
	logic                     tflag_s6, tflag_s7, tflag_s8;

	always_ff @(posedge clk) begin
		off_s6  <= off1_s5 - (low_s5 ? $signed(off2_s5) : OS_W'(0));
		sens_s6 <= sens1_s5 - (low_s5 ? $signed(sens2_s5) : OS_W'(0));
		if (temp_s5 < TEMP_LOW) begin
			tsat_s6  <= TEMP_W'(TEMP_LOW);
			tflag_s6 <= 1'b1;
		end else if (temp_s5 > TEMP_HIGH) begin
			tsat_s6  <= TEMP_W'(TEMP_HIGH);
			tflag_s6 <= 1'b1;
		end else begin
			tsat_s6  <= temp_s5[TEMP_W-1:0];
			tflag_s6 <= 1'b0;
		end
		d1_s6 <= d1_s5;
	end

	// stage 7: D1 * SENS as two partial products
	logic [RAW_W+HALF_W-1:0]        pl_s7;
	logic signed [RAW_W+HALF_W:0]   ph_s7;

	always_ff @(posedge clk) begin
		pl_s7    <= d1_s6 * sens_s6[HALF_W-1:0];
		ph_s7    <= $signed({1'b0, d1_s6}) * $signed(sens_s6[OS_W-1:HALF_W]);
		off_s7   <= off_s6;
		tsat_s7  <= tsat_s6;
		tflag_s7 <= tflag_s6;
	end

	// stage 8: combine partial products
	logic signed [P64_W-1:0] ph64, prod_s8;

	assign ph64 = {{(P64_W-RAW_W-HALF_W-1){ph_s7[RAW_W+HALF_W]}}, ph_s7};

	always_ff @(posedge clk) begin
		prod_s8  <= (ph64 <<< HALF_W)
			+ $signed({{(P64_W-RAW_W-HALF_W){1'b0}}, pl_s7});
		off_s8   <= off_s7;
		tsat_s8  <= tsat_s7;
		tflag_s8 <= tflag_s7;
	end

	// stage 9: pressure, clamp, output registers
	localparam int X_W = P64_W - 21;
	localparam int Y_W = X_W + 1;
	localparam int PW  = Y_W - 15;

	logic signed [Y_W-1:0] y_c;
	logic signed [PW-1:0]  p_c;
	logic signed [TEMP_W-1:0] temperature_q;
	logic [PRES_W-1:0]        pressure_q;
	logic                     oor_q;

	assign y_c = $signed({prod_s8[P64_W-1], prod_s8[P64_W-1:21]})
		- $signed({{(Y_W-OS_W){off_s8[OS_W-1]}}, off_s8});
	assign p_c = y_c[Y_W-1:15];

	always_ff @(posedge clk) begin
		temperature_q <= tsat_s8;
		if (p_c < PRES_LOW) begin
			pressure_q <= PRES_W'(PRES_LOW);
			oor_q      <= 1'b1;
		end else if (p_c > PRES_HIGH) begin
			pressure_q <= PRES_W'(PRES_HIGH);
			oor_q      <= 1'b1;
		end else begin
			pressure_q <= p_c[PRES_W-1:0];
			oor_q      <= tflag_s8;
		end
	end

	assign done         = done_q;
	assign temperature  = temperature_q;
	assign pressure     = pressure_q;
	assign out_of_range = oor_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching request");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (temperature >= TEMP_LOW && temperature <= TEMP_HIGH))
		else $error("temperature outside clamp range");

	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pressure >= PRES_LOW && pressure <= PRES_HIGH))
		else $error("pressure outside clamp range");

endmodule

### dv/bptc_checker.sv
module bptc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]          raw_temperature,
	input  logic                                done,
	input  logic signed [bptc_pkg::TEMP_W-1:0]  temperature,
	input  logic [bptc_pkg::PRES_W-1:0]         pressure,
	input  logic                                out_of_range,
	input  logic                                cfg_wr_en,
	input  logic [bptc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bptc_pkg::CAL_W-1:0]          cfg_wdata,
	output int                                  errors,
	output int                                  outstanding
);
	import bptc_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [PRES_W-1:0]        pres;
		logic                     flag;
	} reading_t;

	logic [CAL_W-1:0] sens_base;
	logic [CAL_W-1:0] offset_base;
	logic [CAL_W-1:0] sens_tempco;
	logic [CAL_W-1:0] offset_tempco;
	logic [CAL_W-1:0] ref_temp;
	logic [CAL_W-1:0] temp_slope;

	reading_t expected_readings[$];
	int       mismatch_count = 0;
	int       pending_count  = 0;
	int       result_index   = 0;

	assign errors      = mismatch_count;
	assign outstanding = pending_count;

	// Second-order compensation, all in signed 64 bits; >>> on longint floors.
	function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		longint   d1, d2, dt, t, off, sens, f, t2, off2, sens2, p;
		reading_t r;
		d1   = longint'(d1_raw);
		d2   = longint'(d2_raw);
		dt   = d2 - (longint'(ref_temp) << 8);
		t    = TEMP_BASE + ((dt * longint'(temp_slope)) >>> 23);
		off  = (longint'(offset_base) << 16) + ((longint'(offset_tempco) * dt) >>> 7);
		sens = (longint'(sens_base) << 15) + ((longint'(sens_tempco) * dt) >>> 8);
		if (t < TEMP_BASE) begin
			t2    = (dt * dt) >>> 31;
			f     = (t - TEMP_BASE) * (t - TEMP_BASE);
			off2  = (5 * f) >>> 1;
			sens2 = (5 * f) >>> 2;
			// both thresholds look at the first-order temperature
			if (t < TEMP_VLOW) begin
				f     = (t - TEMP_VLOW) * (t - TEMP_VLOW);
				off2  = off2 + 7 * f;
				sens2 = sens2 + ((11 * f) >>> 1);
			end
			t    = t - t2;
			off  = off - off2;
			sens = sens - sens2;
		end
		p = (((d1 * sens) >>> 21) - off) >>> 15;
		r.flag = 1'b0;
		if (t < TEMP_LOW) begin
			t = TEMP_LOW;
			r.flag = 1'b1;
		end
		if (t > TEMP_HIGH) begin
			t = TEMP_HIGH;
			r.flag = 1'b1;
		end
		if (p < PRES_LOW) begin
			p = PRES_LOW;
			r.flag = 1'b1;
		end
		if (p > PRES_HIGH) begin
			p = PRES_HIGH;
			r.flag = 1'b1;
		end
		r.temp = t[TEMP_W-1:0];
		r.pres = p[PRES_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			sens_base     = '0;
			offset_base   = '0;
			sens_tempco   = '0;
			offset_tempco = '0;
			ref_temp      = '0;
			temp_slope    = '0;
			expected_readings.delete();
			pending_count = 0;
		end else begin
			if (done) begin
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result %0d: no request pending", result_index));
				end else begin
					want = expected_readings.pop_front();
					if (temperature !== want.temp || pressure !== want.pres ||
							out_of_range !== want.flag)
						report_mismatch($sformatf(
							"result %0d: temp %0d/%0d pres %0d/%0d flag %b/%b (got/want)",
							result_index, temperature, want.temp, pressure, want.pres,
							out_of_range, want.flag));
				end
				result_index++;
			end
			if (start && !busy)
				expected_readings.push_back(compensate(raw_pressure, raw_temperature));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SENS_BASE:     sens_base     = cfg_wdata;
					REG_OFFSET_BASE:   offset_base   = cfg_wdata;
					REG_SENS_TEMPCO:   sens_tempco   = cfg_wdata;
					REG_OFFSET_TEMPCO: offset_tempco = cfg_wdata;
					REG_REF_TEMP:      ref_temp      = cfg_wdata;
					REG_TEMP_SLOPE:    temp_slope    = cfg_wdata;
					default: ;
				endcase
			end
			pending_count = expected_readings.size();
		end
	end

endmodule

### dv/testbench.sv
module testbench;
	import bptc_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [IDX_W-1:0] REG_ORDER [6] = '{REG_SENS_BASE, REG_OFFSET_BASE,
		REG_SENS_TEMPCO, REG_OFFSET_TEMPCO, REG_REF_TEMP, REG_TEMP_SLOPE};
	localparam logic [CAL_W-1:0] TYPICAL_CAL [6] = '{16'd40127, 16'd36924, 16'd23317,
		16'd23282, 16'd33464, 16'd28312};

	localparam int NUM_DIRECTED     = 16;
	localparam int NUM_PHASES       = 8;
	localparam int REQUESTS_PER_PHASE = 56;
	localparam int QUIET_TAIL       = 60;

	// directed pairs, chosen for the typical calibration set
	localparam logic [RAW_W-1:0] DIR_PRES [NUM_DIRECTED] = '{
		24'd9085466, 24'd9085466, 24'd9085466, 24'd9085466,
		24'd9085466, 24'd9085466, 24'd9085466, 24'd9085466,
		24'd9085466, 24'd0,       24'hFFFFFF,  24'd4000000,
		24'd12000000, 24'hFFFFFF, 24'd0,       24'hAAAAAA};
	localparam logic [RAW_W-1:0] DIR_TEMP [NUM_DIRECTED] = '{
		24'd8569150, 24'd8566784, 24'd8566783, 24'd8000000,
		24'd7529000, 24'd7531000, 24'd6500000, 24'd10600000,
		24'd10400000, 24'd8569150, 24'd8569150, 24'd8569150,
		24'd7529000, 24'd0,       24'hFFFFFF,  24'h555555};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [RAW_W-1:0]         raw_pressure;
	logic [RAW_W-1:0]         raw_temperature;
	logic                     done;
	logic signed [TEMP_W-1:0] temperature;
	logic [PRES_W-1:0]        pressure;
	logic                     out_of_range;
	logic                     cfg_wr_en;
	logic [IDX_W-1:0]         cfg_index;
	logic [CAL_W-1:0]         cfg_wdata;
	int                       errors;
	int                       outstanding;

	logic [CAL_W-1:0]         cal_words [6];

	baro_pressure_temp_compensation_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.done            (done),
		.temperature     (temperature),
		.pressure        (pressure),
		.out_of_range    (out_of_range),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	bptc_checker check_unit (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.done            (done),
		.temperature     (temperature),
		.pressure        (pressure),
		.out_of_range    (out_of_range),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.errors          (errors),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("baro_pressure_temp_compensation_unit: mismatch");
		$finish;
	end

	// hold the request until the pipeline takes it
	task automatic issue(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		start           <= 1'b1;
		raw_pressure    <= p;
		raw_temperature <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle(input int cycles);
		start           <= 1'b0;
		raw_pressure    <= RAW_W'($urandom);
		raw_temperature <= RAW_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_idle(input bit quiet);
		if (!quiet && $urandom_range(0, 3) == 0)
			idle($urandom_range(1, 17));
	endtask

	// drop start and wait until every expected reading has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic program_calibration(input bit poke_spare);
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_wdata <= cal_words[i];
			@(posedge clk);
		end
		if (poke_spare) begin
			cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
			cfg_wdata <= CAL_W'($urandom);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cfg_wdata <= CAL_W'($urandom);
	endtask

	// mostly near the reference temperature, so both correction bands get hit
	function automatic logic [RAW_W-1:0] pick_raw_temperature();
		longint v;
		longint mag;
		int     k;
		if ($urandom_range(0, 3) == 0)
			return RAW_W'($urandom);
		k   = $urandom_range(2, 22);
		mag = longint'($urandom_range(0, (1 << k) - 1));
		if ($urandom_range(0, 1))
			mag = -mag;
		v = (longint'(cal_words[REG_REF_TEMP]) << 8) + mag;
		if (v < 0)
			v = 0;
		if (v > longint'(24'hFFFFFF))
			v = longint'(24'hFFFFFF);
		return v[RAW_W-1:0];
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_pressure();
		if ($urandom_range(0, 2) == 0)
			return RAW_W'($urandom);
		return RAW_W'($urandom_range(6000000, 12000000));
	endfunction

	initial begin
		bit quiet;
		arst_n          = 1'b0;
		start           = 1'b0;
		raw_pressure    = '0;
		raw_temperature = '0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		for (int w = 0; w < 6; w++)
			cal_words[w] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at its reset value
		issue('0, '0);
		issue('1, '1);
		maybe_idle(1'b0);
		issue('0, '1);
		issue('1, '0);
		drain();

		for (int w = 0; w < 6; w++)
			cal_words[w] = TYPICAL_CAL[w];
		program_calibration(1'b1);
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			issue(DIR_PRES[i], DIR_TEMP[i]);
			maybe_idle(1'b0);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			for (int w = 0; w < 6; w++) begin
				if (ph == 0)
					cal_words[w] = '1;
				else if (ph == 1)
					cal_words[w] = (w % 2) ? '1 : '0;
				else if (ph == 2)
					cal_words[w] = TYPICAL_CAL[w];
				else
					case ($urandom_range(0, 4))
						0:       cal_words[w] = '0;
						1:       cal_words[w] = '1;
						2:       cal_words[w] = CAL_W'($urandom);
						default: cal_words[w] = TYPICAL_CAL[w] +
							CAL_W'($urandom_range(0, 8191)) - 16'd4096;
					endcase
			end
			program_calibration($urandom_range(0, 1));
			for (int i = 0; i < REQUESTS_PER_PHASE; i++) begin
				quiet = (ph == NUM_PHASES - 1) && (i >= REQUESTS_PER_PHASE - QUIET_TAIL);
				issue(pick_raw_pressure(), pick_raw_temperature());
				maybe_idle(quiet);
			end
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("baro_pressure_temp_compensation_unit: match");
		else
			$display("baro_pressure_temp_compensation_unit: mismatch");
		$finish;
	end

endmodule
